// File: rtl/core/tsi_pkg.sv
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared constants, types and the sine table builder for the table sine unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tsi_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int TABLE_BITS    = $clog2(TABLE_ENTRIES);

  localparam int ANGLE_W  = 24;
  localparam int MAG_W    = 24;
  localparam int SINE_W   = 16;
  localparam int SAMPLE_W = 18;
  localparam int DELTA_W  = 14;
  localparam int WORD_W   = SAMPLE_W + DELTA_W;
  localparam int FRAC_W   = 16;
  localparam int INV_W    = 30;
  localparam int PROD_W   = MAG_W + INV_W;
  localparam int TURN_TOP = 47;
  localparam int TURN_W   = TABLE_BITS + FRAC_W;
  localparam int PRODUCT_W = FRAC_W + 1 + DELTA_W;
  localparam int VALUE_W  = SAMPLE_W + 1;

  localparam logic [INV_W-1:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [63:0]      HALF_PI_Q30    = 64'd1686629713;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } tsi_adv_t;

  function automatic logic [SAMPLE_W-1:0] quadrant_sine(input logic [63:0] u);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] plus;
    logic [63:0] minus;
    logic [63:0] sum;
    logic [63:0] rnd;
    x     = (u * HALF_PI_Q30 + 64'(TABLE_ENTRIES / 2)) / 64'(TABLE_ENTRIES);
    x2    = (x * x) >> 30;
    plus  = x;
    minus = 64'd0;
    term  = ((x * x2) >> 30) / 64'd6;
    minus = minus + term;
    term  = ((term * x2) >> 30) / 64'd20;
    plus  = plus + term;
    term  = ((term * x2) >> 30) / 64'd42;
    minus = minus + term;
    term  = ((term * x2) >> 30) / 64'd72;
    plus  = plus + term;
    term  = ((term * x2) >> 30) / 64'd110;
    minus = minus + term;
    term  = ((term * x2) >> 30) / 64'd156;
    plus  = plus + term;
    sum   = (plus > minus) ? plus - minus : 64'd0;
    rnd   = (sum + 64'd16384) >> 15;
    return rnd[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sample_at(input logic [31:0] i);
    logic [63:0] n;
    logic [63:0] u;
    logic        neg;
    logic [SAMPLE_W-1:0] v;
    n   = 64'(TABLE_ENTRIES);
    u   = (64'd4 * {32'd0, i}) % 64'(4 * TABLE_ENTRIES);
    neg = 1'b0;
    if (u >= 64'd2 * n) begin
      neg = 1'b1;
      u   = u - 64'd2 * n;
    end
    if (u > n) begin
      u = 64'd2 * n - u;
    end
    v = quadrant_sine(u);
    return neg ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic [WORD_W-1:0] sine_word(input logic [31:0] i);
    logic signed [SAMPLE_W-1:0] s;
    logic signed [SAMPLE_W-1:0] s_next;
    logic signed [SAMPLE_W-1:0] d;
    s      = sample_at(i);
    s_next = sample_at((i + 32'd1) % 32'(TABLE_ENTRIES));
    d      = s_next - s;
    return {d[DELTA_W-1:0], s};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/table_sine_interpolated_unit.sv
// ----------------------------------------------------------------------------
// table_sine_interpolated_unit
// Sine of a Q8.16 angle by table lookup with optional linear interpolation.
// Pipeline stages from input transfer to output transfer, in order: magnitude, turn
// multiply, table read, delta multiply, round and saturate.
// Throughput: one transfer per cycle while out_stall is low; each stage holds its item on stall.
// Reset clears all stage valid bits and sets interpolate mode to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module table_sine_interpolated_unit
  import tsi_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [ANGLE_W-1:0] in_angle,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [SINE_W-1:0]       out_sine_value,
  input  wire logic                      cfg_wr_en,
  input  wire logic                      cfg_wr_data
);

  tsi_adv_t            adv;
  logic                mode_r;
  logic                v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [TURN_W-1:0]   turn;
  logic                neg2;
  logic [WORD_W-1:0]   word;
  logic [FRAC_W-1:0]   frac;
  logic                neg3;

  // advance a stage when it is empty or the next one advances
  always_comb begin
    adv.s5 = !v5_r || !out_stall;
    adv.s4 = !v4_r || adv.s5;
    adv.s3 = !v3_r || adv.s4;
    adv.s2 = !v2_r || adv.s3;
    adv.s1 = !v1_r || adv.s2;
  end

  assign in_stall = !adv.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (adv.s1) v1_r <= in_valid;
      if (adv.s2) v2_r <= v1_r;
      if (adv.s3) v3_r <= v2_r;
      if (adv.s4) v4_r <= v3_r;
      if (adv.s5) v5_r <= v4_r;
    end
  end

  tsi_scale u_scale (
    .clk   (clk),
    .adv   (adv),
    .angle (in_angle),
    .turn  (turn),
    .neg   (neg2)
  );

  tsi_lookup u_lookup (
    .clk    (clk),
    .adv    (adv),
    .mode   (mode_r),
    .turn   (turn),
    .neg_in (neg2),
    .word   (word),
    .frac   (frac),
    .neg    (neg3)
  );

  tsi_interp u_interp (
    .clk    (clk),
    .adv    (adv),
    .mode   (mode_r),
    .word   (word),
    .frac   (frac),
    .neg_in (neg3),
    .sine   (out_sine_value)
  );

  assign out_valid = v5_r;

  a_empty_front_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> !in_stall)
    else $error("input stalled with empty first stage");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("transfer not captured in first stage");

  a_stage4_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && adv.s5) |=> v5_r)
    else $error("item lost between stage 4 and output");

  a_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && out_stall) |=> (v5_r && $stable(out_sine_value)))
    else $error("stalled result dropped or changed");

endmodule

`default_nettype wire

// File: rtl/core/tsi_scale.sv
// ----------------------------------------------------------------------------
// tsi_scale
// Stages 1-2: angle magnitude and sign, then scaling to fractional turns.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_scale
  import tsi_pkg::*;
(
  input  wire logic                      clk,
  input  wire tsi_adv_t                  adv,
  input  wire logic signed [ANGLE_W-1:0] angle,
  output logic             [TURN_W-1:0]  turn,
  output logic                           neg
);

  logic [MAG_W-1:0]  mag_r;
  logic [MAG_W-1:0]  mag_nxt;
  logic              neg1_r;
  logic [PROD_W-1:0] prod;
  logic [TURN_W-1:0] turn_r;
  logic              neg2_r;

  always_comb begin
    mag_nxt = angle[ANGLE_W-1] ? MAG_W'(-angle) : MAG_W'(angle);
    prod    = PROD_W'(mag_r) * PROD_W'(INV_TWO_PI_Q32);
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      mag_r  <= mag_nxt;
      neg1_r <= angle[ANGLE_W-1];
    end
    if (adv.s2) begin
      turn_r <= prod[TURN_TOP -: TURN_W];
      neg2_r <= neg1_r;
    end
  end

  assign turn = turn_r;
  assign neg  = neg2_r;

endmodule

`default_nettype wire

// File: rtl/core/tsi_lookup.sv
// ----------------------------------------------------------------------------
// tsi_lookup
// Stage 3: table index selection and registered sine table read.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_lookup
  import tsi_pkg::*;
(
  input  wire logic              clk,
  input  wire tsi_adv_t          adv,
  input  wire logic              mode,
  input  wire logic [TURN_W-1:0] turn,
  input  wire logic              neg_in,
  output logic [WORD_W-1:0]      word,
  output logic [FRAC_W-1:0]      frac,
  output logic                   neg
);

  logic [WORD_W-1:0]     rom_c [TABLE_ENTRIES];
  logic [TABLE_BITS-1:0] idx;
  logic [WORD_W-1:0]     word_r;
  logic [FRAC_W-1:0]     frac_r;
  logic                  neg3_r;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_rom
    assign rom_c[g] = sine_word(32'(g));
  end

  // nearest mode rounds on the top fraction bit; the index wraps at the end
  always_comb begin
    idx = turn[TURN_W-1 -: TABLE_BITS];
    if (!mode) begin
      idx = idx + TABLE_BITS'(turn[FRAC_W-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      word_r <= rom_c[idx];
      frac_r <= turn[FRAC_W-1:0];
      neg3_r <= neg_in;
    end
  end

  assign word = word_r;
  assign frac = frac_r;
  assign neg  = neg3_r;

endmodule

`default_nettype wire

// File: rtl/core/tsi_interp.sv
// ----------------------------------------------------------------------------
// tsi_interp
// Stages 4-5: fraction times delta, rounding, sign and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_interp
  import tsi_pkg::*;
(
  input  wire logic               clk,
  input  wire tsi_adv_t           adv,
  input  wire logic               mode,
  input  wire logic [WORD_W-1:0]  word,
  input  wire logic [FRAC_W-1:0]  frac,
  input  wire logic               neg_in,
  output logic signed [SINE_W-1:0] sine
);

  logic signed [DELTA_W-1:0]   delta;
  logic signed [PRODUCT_W-1:0] prod_r;
  logic signed [SAMPLE_W-1:0]  sample_r;
  logic                        neg4_r;
  logic signed [PRODUCT_W:0]   rnd;
  logic signed [SINE_W-1:0]    q;
  logic signed [VALUE_W-1:0]   v;
  logic signed [VALUE_W:0]     sv;
  logic signed [SINE_W-1:0]    sine_nxt;
  logic signed [SINE_W-1:0]    sine_r;

  assign delta = $signed(word[WORD_W-1 -: DELTA_W]);

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      prod_r   <= PRODUCT_W'($signed({1'b0, frac})) * PRODUCT_W'(delta);
      sample_r <= $signed(word[SAMPLE_W-1:0]);
      neg4_r   <= neg_in;
    end
    if (adv.s5) begin
      sine_r <= sine_nxt;
    end
  end

  always_comb begin
    rnd = $signed({prod_r[PRODUCT_W-1], prod_r}) + (PRODUCT_W+1)'(32768);
    q   = rnd[PRODUCT_W -: SINE_W];
    v   = $signed({sample_r[SAMPLE_W-1], sample_r});
    if (mode) begin
      v = v + VALUE_W'(q);
    end
    sv = $signed({v[VALUE_W-1], v});
    if (neg4_r) begin
      sv = -sv;
    end
    if (sv > (VALUE_W+1)'(32767)) begin
      sine_nxt = 16'sh7FFF;
    end else if (sv < -(VALUE_W+1)'(32768)) begin
      sine_nxt = 16'sh8000;
    end else begin
      sine_nxt = sv[SINE_W-1:0];
    end
  end

  assign sine = sine_r;

endmodule

`default_nettype wire
